### hw/rtl/dfcc_pkg.sv
// dfcc_pkg: shared constants, types and helper functions for the disk
// footprint collision check. No dependencies.
package dfcc_pkg;

    localparam int MAP_WIDTH_MAX  = 256;
    localparam int MAP_HEIGHT_MAX = 256;
    localparam int RADIUS_MAX     = 15;

    localparam logic [7:0] OBSTACLE_BELOW = 8'd127;

    localparam int CELL_W  = 11;
    localparam int COORD_W = CELL_W + 1;
    localparam int DIM_W   = 9;
    localparam int RAD_W   = 4;
    localparam int PIX_W   = 8;
    localparam int OFS_W   = RAD_W + 1;
    localparam int SQ_W    = 2 * OFS_W + 1;
    localparam int COL_W   = $clog2(MAP_WIDTH_MAX);
    localparam int ROW_W   = $clog2(MAP_HEIGHT_MAX);
    localparam int MAP_DEPTH = MAP_WIDTH_MAX * MAP_HEIGHT_MAX;
    localparam int ADDR_W  = $clog2(MAP_DEPTH);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        REG_MAP_WIDTH    = 2'd0,
        REG_MAP_HEIGHT   = 2'd1,
        REG_RADIUS_CELLS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic step;
        logic write;
    } dp_cmd_t;

    typedef struct packed {
        logic obstacle;
        logic last;
    } dp_stat_t;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v, input int lim);
        logic [DIM_W-1:0] r;
        r = v;
        if (int'(v) > lim)
            r = DIM_W'(lim);
        return r;
    endfunction

    function automatic logic in_map(input logic signed [COORD_W-1:0] v,
                                    input logic [DIM_W-1:0] lim);
        return !v[COORD_W-1] && (v[COORD_W-2:0] < {{(COORD_W-1-DIM_W){1'b0}}, lim});
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [COORD_W-1:0] x,
                                                    input logic signed [COORD_W-1:0] y);
        return ADDR_W'(ADDR_W'(y[ROW_W-1:0]) * MAP_WIDTH_MAX + ADDR_W'(x[COL_W-1:0]));
    endfunction

endpackage

### hw/rtl/dfcc_ram.sv
// dfcc_ram: generic single-port RAM with registered read.
// No dependencies.
module dfcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

### hw/rtl/dfcc_ctrl.sv
// dfcc_ctrl: request handshake, scan sequencing and result register.
// Depends on dfcc_pkg.
module dfcc_ctrl import dfcc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     cmd,
    output logic     out_valid,
    input  logic     out_ready,
    output logic     free,
    output dp_cmd_t  dp_cmd,
    input  dp_stat_t dp_stat
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   result_reg, result_next;
    logic   out_valid_reg, out_valid_next;
    logic   free_reg, free_next;
    logic   accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign free      = free_reg;

    always_comb
    begin
        state_next     = state_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        free_next      = free_reg;
        dp_cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                dp_cmd.write = accept && (cmd == CMD_WRITE);
                dp_cmd.load  = accept && (cmd == CMD_QUERY);
                if (dp_cmd.load)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                dp_cmd.step = 1'b1;
                if (dp_stat.obstacle)
                begin
                    result_next = 1'b0;
                    state_next  = ST_RESULT;
                end
                else if (dp_stat.last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                result_next = !dp_stat.obstacle;
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    free_next      = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        free_reg   <= free_next;
    end

endmodule

### hw/rtl/dfcc_datapath.sv
// dfcc_datapath: map RAM, scan offset counters, bounds and disk tests.
// Depends on dfcc_pkg and dfcc_ram.
module dfcc_datapath import dfcc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  dp_cmd,
    output dp_stat_t                 dp_stat,
    input  logic [DIM_W-1:0]         map_width,
    input  logic [DIM_W-1:0]         map_height,
    input  logic [RAD_W-1:0]         radius_cells,
    input  logic signed [CELL_W-1:0] cell_x,
    input  logic signed [CELL_W-1:0] cell_y,
    input  logic [PIX_W-1:0]         pixel_value
);

    logic signed [CELL_W-1:0] cx_reg, cy_reg;
    logic [RAD_W-1:0]         r_reg;
    logic [DIM_W-1:0]         w_reg, h_reg;
    logic signed [OFS_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic                     pending_reg;

    logic [DIM_W-1:0]         eff_w, eff_h;
    logic [RAD_W-1:0]         eff_r;
    logic signed [OFS_W-1:0]  r_ofs, load_ofs;
    logic signed [COORD_W-1:0] sx, sy, wx, wy;
    logic signed [SQ_W-1:0]   dx_ext, dy_ext, r_ext, dsq, rsq;
    logic                     cell_ok, wr_ok, last;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    logic [PIX_W-1:0]         ram_rdata;

    assign eff_w    = sat_dim(map_width, MAP_WIDTH_MAX);
    assign eff_h    = sat_dim(map_height, MAP_HEIGHT_MAX);
    assign eff_r    = (int'(radius_cells) > RADIUS_MAX) ? RAD_W'(RADIUS_MAX) : radius_cells;
    assign load_ofs = -$signed({1'b0, eff_r});
    assign r_ofs    = $signed({1'b0, r_reg});

    // scan cell
    assign sx      = COORD_W'(cx_reg) + COORD_W'(dx_reg);
    assign sy      = COORD_W'(cy_reg) + COORD_W'(dy_reg);
    assign dx_ext  = SQ_W'(dx_reg);
    assign dy_ext  = SQ_W'(dy_reg);
    assign r_ext   = SQ_W'(r_ofs);
    assign dsq     = dx_ext * dx_ext + dy_ext * dy_ext;
    assign rsq     = r_ext * r_ext;
    assign cell_ok = in_map(sx, w_reg) && in_map(sy, h_reg) && (dsq < rsq);
    assign last    = (dx_reg == r_ofs) && (dy_reg == r_ofs);

    // pixel write
    assign wx     = COORD_W'(cell_x);
    assign wy     = COORD_W'(cell_y);
    assign wr_ok  = in_map(wx, eff_w) && in_map(wy, eff_h);
    assign ram_we = dp_cmd.write && wr_ok;

    assign ram_addr = dp_cmd.write ? cell_addr(wx, wy) : cell_addr(sx, sy);

    assign dp_stat.obstacle = pending_reg && (ram_rdata < OBSTACLE_BELOW);
    assign dp_stat.last     = last;

    always_comb
    begin
        dx_next = dx_reg;
        dy_next = dy_reg;
        if (dp_cmd.load)
        begin
            dx_next = load_ofs;
            dy_next = load_ofs;
        end
        else if (dp_cmd.step && !last)
        begin
            if (dy_reg == r_ofs)
            begin
                dy_next = -r_ofs;
                dx_next = dx_reg + OFS_W'(1);
            end
            else
                dy_next = dy_reg + OFS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg      <= '0;
            dy_reg      <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            pending_reg <= dp_cmd.step && cell_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cx_reg <= cell_x;
            cy_reg <= cell_y;
            r_reg  <= eff_r;
            w_reg  <= eff_w;
            h_reg  <= eff_h;
        end
    end

    dfcc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pixel_value),
        .rdata (ram_rdata)
    );

endmodule

### hw/rtl/disk_footprint_collision_check.sv
// disk_footprint_collision_check: top level, APB register file plus
// controller and datapath. Depends on dfcc_pkg, dfcc_ctrl, dfcc_datapath.
//
//  channel   signals                               request
//  in        in_valid/in_ready                     cmd, cell_x, cell_y, pixel_value
//  out       out_valid/out_ready                   free
//  apb       psel/penable/pwrite/pready            paddr, pwdata, prdata
//
// A query, r the saturated radius, holds off the input while it scans the
// (2r+1)^2 cells around its cell, one map cell per cycle through the single
// map RAM port, ending early at an obstacle, and while its result waits for
// the previous result to be taken. New requests are taken only when no query
// is in flight; a result already in the output register does not block them.
// The map is not cleared by reset; registers reset to 256, 256, 0.
module disk_footprint_collision_check import dfcc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cmd,
    input  logic signed [CELL_W-1:0] cell_x,
    input  logic signed [CELL_W-1:0] cell_y,
    input  logic [PIX_W-1:0]         pixel_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     free,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    logic [DIM_W-1:0] map_width_reg, map_height_reg;
    logic [RAD_W-1:0] radius_cells_reg;
    logic             cfg_wr;
    reg_idx_t         reg_idx;
    dp_cmd_t          dp_cmd;
    dp_stat_t         dp_stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= DIM_W'(256);
            map_height_reg   <= DIM_W'(256);
            radius_cells_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_MAP_WIDTH:    map_width_reg    <= pwdata[DIM_W-1:0];
                REG_MAP_HEIGHT:   map_height_reg   <= pwdata[DIM_W-1:0];
                REG_RADIUS_CELLS: radius_cells_reg <= pwdata[RAD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MAP_WIDTH:    prdata = PDATA_W'(map_width_reg);
            REG_MAP_HEIGHT:   prdata = PDATA_W'(map_height_reg);
            REG_RADIUS_CELLS: prdata = PDATA_W'(radius_cells_reg);
            default:          prdata = '0;
        endcase
    end

    dfcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .free      (free),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    dfcc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .dp_stat      (dp_stat),
        .map_width    (map_width_reg),
        .map_height   (map_height_reg),
        .radius_cells (radius_cells_reg),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .pixel_value  (pixel_value)
    );

endmodule
